[design/radio_seek_controller_assert.svh]
// ----------------------------------------------------------------------------
// Seek controller assertion macros
// Short forms for the clocked, reset-qualified checks of the seek controller.
// ----------------------------------------------------------------------------
`ifndef RADIO_SEEK_CONTROLLER_ASSERT_SVH
`define RADIO_SEEK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define RSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define RSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[design/rsc_pkg.sv]
// ----------------------------------------------------------------------------
// Seek controller package
// Codes, field widths and band limits shared by the seek controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package rsc_pkg;

    localparam int FREQ_W      = 17;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int STEP_W      = 10;
    localparam int AM_STEP_W   = 7;
    localparam int OFFSET_W    = 7;
    localparam int CMD_FREQ_W  = 15;

    // Item modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_REPORT = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;

    // Result kinds
    localparam logic KIND_TUNE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FM_STEP         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AM_STEP         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RSSI_LIMIT_FM   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RSSI_LIMIT_AM   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_LIMIT_FM = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_LIMIT_AM = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LIMIT     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_MULTIPATH_LIMIT = 3'd7;

    // Sub-band numbers
    localparam logic [2:0] SB_FM = 3'd0;
    localparam logic [2:0] SB_LW = 3'd1;
    localparam logic [2:0] SB_MW = 3'd2;
    localparam logic [2:0] SB_SW = 3'd3;
    localparam logic [2:0] SB_WX = 3'd4;

    // Band edges in kHz
    localparam logic [FREQ_W-1:0] FM_LOW  = 17'd87500;
    localparam logic [FREQ_W-1:0] FM_HIGH = 17'd108000;
    localparam logic [FREQ_W-1:0] LW_LOW  = 17'd144;
    localparam logic [FREQ_W-1:0] LW_HIGH = 17'd288;
    localparam logic [FREQ_W-1:0] MW_LOW  = 17'd880;
    localparam logic [FREQ_W-1:0] MW_HIGH = 17'd1710;
    localparam logic [FREQ_W-1:0] SW_LOW  = 17'd2300;
    localparam logic [FREQ_W-1:0] SW_HIGH = 17'd27000;
    localparam logic [FREQ_W-1:0] WX_LOW  = 17'd1;
    localparam logic [FREQ_W-1:0] WX_HIGH = 17'd7;

    localparam logic [7:0] SEARCH_CODE = 8'h20;
    localparam logic [2:0] READY_MIN   = 3'd5;

    // x / 10 as (x * 104858) >> 20, exact for every 17-bit x
    localparam logic [16:0] DIV10_RECIP = 17'd104858;
    localparam int          DIV10_SHIFT = 20;

endpackage

`default_nettype wire

[design/rsc_item_if.sv]
// ----------------------------------------------------------------------------
// Seek controller input channel
// Valid/ready channel carrying start, quality report and stop items.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsc_item_if import rsc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic              direction;
    logic              band_fm;
    logic [FREQ_W-1:0] start_freq;
    logic [7:0]        status_byte;
    logic [7:0]        level_byte;
    logic [7:0]        noise_byte;
    logic [7:0]        multipath_byte;
    logic [7:0]        offset_byte;
    logic              stop_value;

    modport source (
        output valid, mode, direction, band_fm, start_freq, status_byte,
               level_byte, noise_byte, multipath_byte, offset_byte, stop_value,
        input  ready
    );

    modport sink (
        input  valid, mode, direction, band_fm, start_freq, status_byte,
               level_byte, noise_byte, multipath_byte, offset_byte, stop_value,
        output ready
    );

endinterface

`default_nettype wire

[design/rsc_result_if.sv]
// ----------------------------------------------------------------------------
// Seek controller result channel
// Valid/ready channel carrying tune commands and seek-finished results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsc_result_if import rsc_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              kind;
    logic [7:0]        cmd_mode;
    logic [6:0]        cmd_freq_high;
    logic [7:0]        cmd_freq_low;
    logic              found;
    logic [FREQ_W-1:0] freq;

    modport source (
        output valid, kind, cmd_mode, cmd_freq_high, cmd_freq_low, found, freq,
        input  ready
    );

    modport sink (
        input  valid, kind, cmd_mode, cmd_freq_high, cmd_freq_low, found, freq,
        output ready
    );

endinterface

`default_nettype wire

[design/radio_seek_controller.sv]
// ----------------------------------------------------------------------------
// Radio seek controller
// Steps a tuner through a sub-band, issues search-tune commands and judges
// quality reports until a station is found, the band wraps or a stop is set.
// ----------------------------------------------------------------------------
// Usage:
//   item   : start, quality report and stop items (valid/ready, transfer when
//            both are high).
//   result : one tune command or one seek-finished result per start item and
//            per ready report taken while seeking; other items give nothing.
//   cfg_*  : register writes, taken whenever cfg_we is high; write only while
//            the block is idle.
//   Each item is handled in the cycle of its transfer; its result is shown
//   from the next cycle in the output register. One item per cycle is sustained
//   while results are taken, set by the single add/compare/divide-by-ten pass.
//   A stalled receiver holds the output register; item ready stays high while
//   that register is empty or being drained in the same cycle.
//   Reset returns the registers to their defaults, stops any seek, clears the
//   stop flag and empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_seek_controller import rsc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rsc_item_if.sink               item,
    rsc_result_if.source           result
);

    // Configuration registers
    logic [STEP_W-1:0]    fm_step_reg;
    logic [AM_STEP_W-1:0] am_step_reg;
    logic [7:0]           rssi_limit_fm_reg;
    logic [7:0]           rssi_limit_am_reg;
    logic [OFFSET_W-1:0]  offset_limit_fm_reg;
    logic [OFFSET_W-1:0]  offset_limit_am_reg;
    logic [7:0]           noise_limit_reg;
    logic [7:0]           multipath_limit_reg;

    // Seek state
    logic              seeking_reg, seeking_next;
    logic [FREQ_W-1:0] cur_freq_reg, cur_freq_next;
    logic [FREQ_W-1:0] origin_reg, origin_next;
    logic              wrapped_reg, wrapped_next;
    logic              down_reg, down_next;
    logic              fm_reg, fm_next;
    logic [2:0]        sub_band_reg, sub_band_next;
    logic              stop_reg, stop_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [7:0]        cmd_mode_reg, cmd_mode_next;
    logic [CMD_FREQ_W-1:0] cmd_freq_reg, cmd_freq_next;
    logic              found_reg, found_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;

    // Working signals
    logic                  accept;
    logic                  is_start, is_report, is_stop;
    logic                  report_ready;
    logic                  pass;
    logic                  do_advance, do_found;
    logic [FREQ_W-1:0]     base_freq, base_origin;
    logic                  base_down, base_fm, base_wrapped;
    logic [2:0]            base_sb, start_sb;
    logic [FREQ_W-1:0]     band_lo, band_hi;
    logic [STEP_W-1:0]     step;
    logic [FREQ_W:0]       up_sum, down_floor;
    logic                  up_over, down_under;
    logic [FREQ_W-1:0]     step_freq;
    logic                  step_wrap, end_cycle;
    logic [33:0]           div_prod;
    logic [CMD_FREQ_W-1:0] cmd_freq;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign is_start   = item.mode == MODE_START;
    assign is_report  = item.mode == MODE_REPORT;
    assign is_stop    = item.mode == MODE_STOP;

    // Sub-band of a start frequency
    always_comb
    begin
        if (item.band_fm)
            start_sb = SB_FM;
        else if (item.start_freq >= LW_LOW && item.start_freq <= LW_HIGH)
            start_sb = SB_LW;
        else if (item.start_freq >= MW_LOW && item.start_freq <= MW_HIGH)
            start_sb = SB_MW;
        else if (item.start_freq >= SW_LOW && item.start_freq <= SW_HIGH)
            start_sb = SB_SW;
        else
            start_sb = SB_WX;
    end

    // A start item loads the seek before its first step
    assign base_freq    = is_start ? item.start_freq : cur_freq_reg;
    assign base_origin  = is_start ? item.start_freq : origin_reg;
    assign base_down    = is_start ? item.direction  : down_reg;
    assign base_fm      = is_start ? item.band_fm    : fm_reg;
    assign base_wrapped = is_start ? 1'b0            : wrapped_reg;
    assign base_sb      = is_start ? start_sb        : sub_band_reg;

    always_comb
    begin
        case (base_sb)
            SB_FM:
            begin
                band_lo = FM_LOW;
                band_hi = FM_HIGH;
            end
            SB_LW:
            begin
                band_lo = LW_LOW;
                band_hi = LW_HIGH;
            end
            SB_MW:
            begin
                band_lo = MW_LOW;
                band_hi = MW_HIGH;
            end
            SB_SW:
            begin
                band_lo = SW_LOW;
                band_hi = SW_HIGH;
            end
            default:
            begin
                band_lo = WX_LOW;
                band_hi = WX_HIGH;
            end
        endcase
    end

    assign step       = base_fm ? fm_step_reg : {{(STEP_W-AM_STEP_W){1'b0}}, am_step_reg};
    assign up_sum     = {1'b0, base_freq} + {{(FREQ_W+1-STEP_W){1'b0}}, step};
    assign down_floor = {1'b0, band_lo} + {{(FREQ_W+1-STEP_W){1'b0}}, step};
    assign up_over    = up_sum > {1'b0, band_hi};
    assign down_under = {1'b0, base_freq} < down_floor;

    // Step one channel, wrapping to the opposite edge
    always_comb
    begin
        if (!base_down)
        begin
            step_freq = up_over ? band_lo : up_sum[FREQ_W-1:0];
            step_wrap = base_wrapped || up_over;
            end_cycle = step_wrap && (step_freq >= base_origin);
        end
        else
        begin
            step_freq = down_under ? band_hi
                                   : base_freq - {{(FREQ_W-STEP_W){1'b0}}, step};
            step_wrap = base_wrapped || down_under;
            end_cycle = step_wrap && (step_freq <= base_origin);
        end
    end

    assign div_prod = {17'd0, step_freq} * {17'd0, DIV10_RECIP};
    assign cmd_freq = base_fm ? {1'b0, div_prod[DIV10_SHIFT+13:DIV10_SHIFT]}
                              : step_freq[CMD_FREQ_W-1:0];

    // Quality test; the offset sign bit is dropped
    assign report_ready = item.status_byte[7:5] >= READY_MIN;
    always_comb
    begin
        if (fm_reg)
            pass = (item.level_byte > rssi_limit_fm_reg)
                && (item.offset_byte[OFFSET_W-1:0] < offset_limit_fm_reg)
                && (item.noise_byte < noise_limit_reg)
                && (item.multipath_byte < multipath_limit_reg);
        else
            pass = (item.level_byte > rssi_limit_am_reg)
                && (item.offset_byte[OFFSET_W-1:0] < offset_limit_am_reg);
    end

    assign do_found   = accept && is_report && seeking_reg && report_ready && pass;
    assign do_advance = accept && (is_start
                      || (is_report && seeking_reg && report_ready && !pass));

    always_comb
    begin
        seeking_next   = seeking_reg;
        cur_freq_next  = cur_freq_reg;
        origin_next    = origin_reg;
        wrapped_next   = wrapped_reg;
        down_next      = down_reg;
        fm_next        = fm_reg;
        sub_band_next  = sub_band_reg;
        stop_next      = stop_reg;
        out_valid_next = out_valid_reg && !result.ready;
        kind_next      = kind_reg;
        cmd_mode_next  = cmd_mode_reg;
        cmd_freq_next  = cmd_freq_reg;
        found_next     = found_reg;
        freq_next      = freq_reg;

        if (accept && is_start)
        begin
            cur_freq_next = item.start_freq;
            origin_next   = item.start_freq;
            down_next     = item.direction;
            fm_next       = item.band_fm;
            sub_band_next = start_sb;
            wrapped_next  = 1'b0;
            seeking_next  = 1'b1;
        end

        if (accept && is_stop)
            stop_next = item.stop_value;

        if (do_advance)
        begin
            out_valid_next = 1'b1;
            if (stop_reg)
            begin
                // stop latched: end at once, no step
                seeking_next  = 1'b0;
                kind_next     = KIND_FINISH;
                cmd_mode_next = 8'd0;
                cmd_freq_next = '0;
                found_next    = 1'b0;
                freq_next     = '0;
            end
            else
            begin
                cur_freq_next = step_freq;
                wrapped_next  = step_wrap;
                if (end_cycle)
                begin
                    seeking_next  = 1'b0;
                    kind_next     = KIND_FINISH;
                    cmd_mode_next = 8'd0;
                    cmd_freq_next = '0;
                    found_next    = 1'b0;
                    freq_next     = '0;
                end
                else
                begin
                    kind_next     = KIND_TUNE;
                    cmd_mode_next = SEARCH_CODE | {5'd0, base_sb};
                    cmd_freq_next = cmd_freq;
                    found_next    = 1'b0;
                    freq_next     = '0;
                end
            end
        end

        if (do_found)
        begin
            seeking_next   = 1'b0;
            out_valid_next = 1'b1;
            kind_next      = KIND_FINISH;
            cmd_mode_next  = 8'd0;
            cmd_freq_next  = '0;
            found_next     = 1'b1;
            freq_next      = cur_freq_reg;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fm_step_reg         <= 10'd100;
            am_step_reg         <= 7'd9;
            rssi_limit_fm_reg   <= 8'd76;
            rssi_limit_am_reg   <= 8'd126;
            offset_limit_fm_reg <= 7'd10;
            offset_limit_am_reg <= 7'd15;
            noise_limit_reg     <= 8'd70;
            multipath_limit_reg <= 8'd60;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FM_STEP:         fm_step_reg         <= cfg_data;
                REG_AM_STEP:         am_step_reg         <= cfg_data[AM_STEP_W-1:0];
                REG_RSSI_LIMIT_FM:   rssi_limit_fm_reg   <= cfg_data[7:0];
                REG_RSSI_LIMIT_AM:   rssi_limit_am_reg   <= cfg_data[7:0];
                REG_OFFSET_LIMIT_FM: offset_limit_fm_reg <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_LIMIT_AM: offset_limit_am_reg <= cfg_data[OFFSET_W-1:0];
                REG_NOISE_LIMIT:     noise_limit_reg     <= cfg_data[7:0];
                REG_MULTIPATH_LIMIT: multipath_limit_reg <= cfg_data[7:0];
                default:             fm_step_reg         <= fm_step_reg;
            endcase
        end
    end

    // Seek state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeking_reg   <= 1'b0;
            cur_freq_reg  <= '0;
            origin_reg    <= '0;
            wrapped_reg   <= 1'b0;
            down_reg      <= 1'b0;
            fm_reg        <= 1'b1;
            sub_band_reg  <= SB_FM;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seeking_reg   <= seeking_next;
            cur_freq_reg  <= cur_freq_next;
            origin_reg    <= origin_next;
            wrapped_reg   <= wrapped_next;
            down_reg      <= down_next;
            fm_reg        <= fm_next;
            sub_band_reg  <= sub_band_next;
            stop_reg      <= stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        cmd_mode_reg <= cmd_mode_next;
        cmd_freq_reg <= cmd_freq_next;
        found_reg    <= found_next;
        freq_reg     <= freq_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = kind_reg;
    assign result.cmd_mode      = cmd_mode_reg;
    assign result.cmd_freq_high = cmd_freq_reg[14:8];
    assign result.cmd_freq_low  = cmd_freq_reg[7:0];
    assign result.found         = found_reg;
    assign result.freq          = freq_reg;

endmodule

`default_nettype wire

[design/rsc_checker.sv]
// ----------------------------------------------------------------------------
// Seek controller checker
// Port-level checks on the seek controller, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radio_seek_controller_assert.svh"

module rsc_checker import rsc_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic [1:0] item_mode,
    input logic [7:0] item_status,
    input logic       result_valid,
    input logic       result_ready
);

    // Held result stays offered
    `RSC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)

    // An empty output register never blocks input
    `RSC_ASSERT_SAME(a_ready_when_empty, !result_valid, item_ready)

    // Every start transfer gives a result in the next cycle
    `RSC_ASSERT_NEXT(a_start_gives_result,
        item_valid && item_ready && item_mode == MODE_START, result_valid)

    // A report that is not ready gives nothing
    `RSC_ASSERT_NEXT(a_unready_report_silent,
        item_valid && item_ready && item_mode == MODE_REPORT
            && item_status[7:5] < READY_MIN, !result_valid)

endmodule

bind radio_seek_controller rsc_checker u_rsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_mode    (item.mode),
    .item_status  (item.status_byte),
    .result_valid (result.valid),
    .result_ready (result.ready)
);

`default_nettype wire
